FILE: hdl/complex_row_current_injection_macros.svh
// Assertion helpers for the file that checks this block.
`ifndef COMPLEX_ROW_CURRENT_INJECTION_MACROS_SVH
`define COMPLEX_ROW_CURRENT_INJECTION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRCI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/crci_pkg.sv
`timescale 1ns / 1ps
package crci_pkg;

   localparam int NODES_DEFAULT = 256;
   localparam int NODE_W = 8;
   localparam int COUNT_W = 9;
   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int TERM_W = 49;
   localparam int ACC_W = 64;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_ENTRY = 1'b1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Control that travels with a row entry down the pipeline.
   typedef struct packed {
      logic valid;
      logic bad;
      logic last;
      logic [NODE_W-1:0] row;
   } ctl_type;

   // Flow control reported by the accumulator back to the front.
   typedef struct packed {
      logic advance;
      logic fin_pending;
   } status_type;

endpackage

FILE: hdl/crci_req_if.sv
`timescale 1ns / 1ps
interface crci_req_if;
   logic valid;
   logic ready;
   logic func;
   logic [7:0] node;
   logic [7:0] row;
   logic signed [31:0] volt_re;
   logic signed [31:0] volt_im;
   logic signed [31:0] cond;
   logic signed [31:0] susc;
   logic last;

   modport source (
      output valid, func, node, row, volt_re, volt_im, cond, susc, last,
      input ready
   );
   modport sink (
      input valid, func, node, row, volt_re, volt_im, cond, susc, last,
      output ready
   );
endinterface

FILE: hdl/crci_rsp_if.sv
`timescale 1ns / 1ps
interface crci_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] row_out;
   logic signed [31:0] curr_re;
   logic signed [31:0] curr_im;
   logic bad_index;
   logic saturated;

   modport source (
      output valid, row_out, curr_re, curr_im, bad_index, saturated,
      input ready
   );
   modport sink (
      input valid, row_out, curr_re, curr_im, bad_index, saturated,
      output ready
   );
endinterface

FILE: hdl/crci_store.sv
`timescale 1ns / 1ps
module crci_store #(
   parameter int NODES = crci_pkg::NODES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   crci_req_if.sink                        req,
   input  logic [crci_pkg::COUNT_W-1:0]    node_count,
   input  logic                            advance,
   output crci_pkg::ctl_type               ctl,
   output logic signed [crci_pkg::DATA_W-1:0] g_val,
   output logic signed [crci_pkg::DATA_W-1:0] b_val,
   output logic signed [crci_pkg::DATA_W-1:0] e_val,
   output logic signed [crci_pkg::DATA_W-1:0] f_val
);
   import crci_pkg::*;

   localparam int AW = $clog2(NODES);

   logic signed [DATA_W-1:0] re_mem [NODES];
   logic signed [DATA_W-1:0] im_mem [NODES];

   logic                     accept;
   logic [AW+NODE_W-1:0]     node_wide;
   logic [AW-1:0]            addr;
   logic                     in_store;
   logic                     in_count;
   ctl_type                  ctl_ff;
   ctl_type                  ctl_in;
   logic signed [DATA_W-1:0] g_ff;
   logic signed [DATA_W-1:0] b_ff;
   logic signed [DATA_W-1:0] e_ff;
   logic signed [DATA_W-1:0] f_ff;

   assign req.ready = advance;
   assign accept = req.valid && advance;

   // Widen first so the address works for stores both smaller and larger than 256.
   assign node_wide = {{AW{1'b0}}, req.node};
   assign addr = node_wide[AW-1:0];
   assign in_store = node_wide < (AW+NODE_W)'(NODES);
   assign in_count = {1'b0, req.node} < node_count;

   always_comb begin
      ctl_in.valid = accept && (req.func == FUNC_ENTRY);
      ctl_in.bad = !(in_store && in_count);
      ctl_in.last = req.last;
      ctl_in.row = req.row;
   end

   always_ff @(posedge clock) begin
      if (accept && (req.func == FUNC_LOAD) && in_store) begin
         re_mem[addr] <= req.volt_re;
         im_mem[addr] <= req.volt_im;
      end
      if (accept) begin
         e_ff <= re_mem[addr];
         f_ff <= im_mem[addr];
         g_ff <= req.cond;
         b_ff <= req.susc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   assign ctl = ctl_ff;
   assign g_val = g_ff;
   assign b_val = b_ff;
   assign e_val = e_ff;
   assign f_val = f_ff;
endmodule

FILE: hdl/crci_mult.sv
`timescale 1ns / 1ps
module crci_mult (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  crci_pkg::ctl_type                   ctl_i,
   input  logic signed [crci_pkg::DATA_W-1:0]  g_val,
   input  logic signed [crci_pkg::DATA_W-1:0]  b_val,
   input  logic signed [crci_pkg::DATA_W-1:0]  e_val,
   input  logic signed [crci_pkg::DATA_W-1:0]  f_val,
   output crci_pkg::ctl_type                   ctl_o,
   output logic signed [crci_pkg::TERM_W-1:0]  term_re,
   output logic signed [crci_pkg::TERM_W-1:0]  term_im
);
   import crci_pkg::*;

   ctl_type                  prod_ctl_ff;
   ctl_type                  term_ctl_ff;
   logic signed [PROD_W-1:0] p_ge_ff;
   logic signed [PROD_W-1:0] p_bf_ff;
   logic signed [PROD_W-1:0] p_gf_ff;
   logic signed [PROD_W-1:0] p_be_ff;
   logic signed [TERM_W-1:0] term_re_ff;
   logic signed [TERM_W-1:0] term_im_ff;
   logic signed [TERM_W-1:0] term_re_in;
   logic signed [TERM_W-1:0] term_im_in;

   // Dropping the low 16 bits of a two's complement product rounds toward minus infinity.
   always_comb begin
      term_re_in = {p_ge_ff[PROD_W-1], p_ge_ff[PROD_W-1:16]}
                 - {p_bf_ff[PROD_W-1], p_bf_ff[PROD_W-1:16]};
      term_im_in = {p_gf_ff[PROD_W-1], p_gf_ff[PROD_W-1:16]}
                 + {p_be_ff[PROD_W-1], p_be_ff[PROD_W-1:16]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ge_ff <= PROD_W'(g_val) * PROD_W'(e_val);
         p_bf_ff <= PROD_W'(b_val) * PROD_W'(f_val);
         p_gf_ff <= PROD_W'(g_val) * PROD_W'(f_val);
         p_be_ff <= PROD_W'(b_val) * PROD_W'(e_val);
         term_re_ff <= term_re_in;
         term_im_ff <= term_im_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         term_ctl_ff <= '0;
      end else if (advance) begin
         prod_ctl_ff <= ctl_i;
         term_ctl_ff <= prod_ctl_ff;
      end
   end

   assign ctl_o = term_ctl_ff;
   assign term_re = term_re_ff;
   assign term_im = term_im_ff;
endmodule

FILE: hdl/crci_accum.sv
`timescale 1ns / 1ps
module crci_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  crci_pkg::ctl_type                   ctl_i,
   input  logic signed [crci_pkg::TERM_W-1:0]  term_re,
   input  logic signed [crci_pkg::TERM_W-1:0]  term_im,
   crci_rsp_if.source                          rsp,
   output crci_pkg::status_type                status
);
   import crci_pkg::*;

   logic                     advance;
   logic signed [ACC_W-1:0]  acc_re_ff;
   logic signed [ACC_W-1:0]  acc_im_ff;
   logic                     bad_seen_ff;
   logic                     sat_seen_ff;
   logic [ACC_W:0]           sum_re;
   logic [ACC_W:0]           sum_im;
   logic                     ovf_re;
   logic                     ovf_im;
   logic signed [ACC_W-1:0]  acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_in;
   logic                     bad_seen_in;
   logic                     sat_seen_in;

   logic                     fin_valid_ff;
   logic signed [ACC_W-1:0]  fin_re_ff;
   logic signed [ACC_W-1:0]  fin_im_ff;
   logic                     fin_bad_ff;
   logic                     fin_sat_ff;
   logic [NODE_W-1:0]        fin_row_ff;
   logic                     clamp_re;
   logic                     clamp_im;
   logic signed [DATA_W-1:0] narrow_re;
   logic signed [DATA_W-1:0] narrow_im;

   logic                     rsp_valid_ff;
   logic [NODE_W-1:0]        rsp_row_ff;
   logic signed [DATA_W-1:0] rsp_re_ff;
   logic signed [DATA_W-1:0] rsp_im_ff;
   logic                     rsp_bad_ff;
   logic                     rsp_sat_ff;

   // The whole pipeline holds only when a finished row waits behind an untaken result.
   assign advance = !(fin_valid_ff && rsp_valid_ff && !rsp.ready);
   assign status.advance = advance;
   assign status.fin_pending = fin_valid_ff;

   always_comb begin
      sum_re = {acc_re_ff[ACC_W-1], acc_re_ff} + (ACC_W+1)'(term_re);
      sum_im = {acc_im_ff[ACC_W-1], acc_im_ff} + (ACC_W+1)'(term_im);
      ovf_re = sum_re[ACC_W] ^ sum_re[ACC_W-1];
      ovf_im = sum_im[ACC_W] ^ sum_im[ACC_W-1];
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      sat_seen_in = sat_seen_ff;
      if (!ctl_i.bad) begin
         if (ovf_re) begin
            acc_re_in = sum_re[ACC_W] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_re_in = sum_re[ACC_W-1:0];
         end
         if (ovf_im) begin
            acc_im_in = sum_im[ACC_W] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_im_in = sum_im[ACC_W-1:0];
         end
         sat_seen_in = sat_seen_ff || ovf_re || ovf_im;
      end
      bad_seen_in = bad_seen_ff || ctl_i.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         bad_seen_ff <= 1'b0;
         sat_seen_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= ctl_i.valid && ctl_i.last;
         if (ctl_i.valid && ctl_i.last) begin
            acc_re_ff <= '0;
            acc_im_ff <= '0;
            bad_seen_ff <= 1'b0;
            sat_seen_ff <= 1'b0;
         end else if (ctl_i.valid) begin
            acc_re_ff <= acc_re_in;
            acc_im_ff <= acc_im_in;
            bad_seen_ff <= bad_seen_in;
            sat_seen_ff <= sat_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ctl_i.valid && ctl_i.last) begin
         fin_re_ff <= acc_re_in;
         fin_im_ff <= acc_im_in;
         fin_bad_ff <= bad_seen_in;
         fin_sat_ff <= sat_seen_in;
         fin_row_ff <= ctl_i.row;
      end
   end

   // A sum fits in 32 bits when its upper 33 bits are all copies of the sign.
   always_comb begin
      clamp_re = !((&fin_re_ff[ACC_W-1:DATA_W-1]) || !(|fin_re_ff[ACC_W-1:DATA_W-1]));
      clamp_im = !((&fin_im_ff[ACC_W-1:DATA_W-1]) || !(|fin_im_ff[ACC_W-1:DATA_W-1]));
      if (clamp_re) begin
         narrow_re = fin_re_ff[ACC_W-1] ? OUT_MIN : OUT_MAX;
      end else begin
         narrow_re = fin_re_ff[DATA_W-1:0];
      end
      if (clamp_im) begin
         narrow_im = fin_im_ff[ACC_W-1] ? OUT_MIN : OUT_MAX;
      end else begin
         narrow_im = fin_im_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_valid_ff && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid_ff && advance) begin
         rsp_row_ff <= fin_row_ff;
         rsp_re_ff <= narrow_re;
         rsp_im_ff <= narrow_im;
         rsp_bad_ff <= fin_bad_ff;
         rsp_sat_ff <= fin_sat_ff || clamp_re || clamp_im;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.row_out = rsp_row_ff;
   assign rsp.curr_re = rsp_re_ff;
   assign rsp.curr_im = rsp_im_ff;
   assign rsp.bad_index = rsp_bad_ff;
   assign rsp.saturated = rsp_sat_ff;
endmodule

FILE: hdl/complex_row_current_injection.sv
// Row current injection for a power-flow step. Load transactions (func 0) write a node's
// real and imaginary voltage into two on-chip stores of NODES entries each; those stores
// are not cleared at reset, so a row entry must only name a node loaded beforehand. Entry
// transactions (func 1) multiply G and B by the column's voltage and add G*e - B*f and
// G*f + B*e into two saturating 64-bit accumulators; the entry with last set returns the
// row's sums clamped to 32 bits, plus flags for out-of-range columns and saturation.
// One transaction is taken every clock cycle unless the input stalls; the closing entry's
// result reaches the rsp channel through the store read, multiply, term combine, accumulate
// and narrowing registers in turn. The accumulator add, which feeds its own register, is
// what fixes that rate. The input stalls only while a finished row waits behind a result the
// sink has not taken. node_count may be written only when no transaction is in flight.
`timescale 1ns / 1ps
`include "complex_row_current_injection_macros.svh"
module complex_row_current_injection #(
   parameter int NODES = crci_pkg::NODES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   crci_req_if.sink                       req_bus,
   crci_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [crci_pkg::COUNT_W-1:0]   csr_wdata
);
   import crci_pkg::*;

   logic [COUNT_W-1:0]       node_count_ff;
   status_type               status;
   ctl_type                  ctl_read;
   ctl_type                  ctl_term;
   logic signed [DATA_W-1:0] g_val;
   logic signed [DATA_W-1:0] b_val;
   logic signed [DATA_W-1:0] e_val;
   logic signed [DATA_W-1:0] f_val;
   logic signed [TERM_W-1:0] term_re;
   logic signed [TERM_W-1:0] term_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_we) begin
         node_count_ff <= csr_wdata;
      end
   end

   crci_store #(
      .NODES(NODES)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .node_count(node_count_ff),
      .advance(status.advance),
      .ctl(ctl_read),
      .g_val(g_val),
      .b_val(b_val),
      .e_val(e_val),
      .f_val(f_val)
   );

   crci_mult u_mult (
      .clock(clock),
      .reset(reset),
      .advance(status.advance),
      .ctl_i(ctl_read),
      .g_val(g_val),
      .b_val(b_val),
      .e_val(e_val),
      .f_val(f_val),
      .ctl_o(ctl_term),
      .term_re(term_re),
      .term_im(term_im)
   );

   crci_accum u_accum (
      .clock(clock),
      .reset(reset),
      .ctl_i(ctl_term),
      .term_re(term_re),
      .term_im(term_im),
      .rsp(rsp_bus),
      .status(status)
   );

   `CRCI_ASSERT_NOW(a_stall_reaches_input, clock, reset, status.fin_pending && rsp_bus.valid && !rsp_bus.ready, !req_bus.ready, "input accepted while a finished row is blocked")
   `CRCI_ASSERT_NEXT(a_stalled_entry_holds, clock, reset, !status.advance && ctl_term.valid, ctl_term.valid && $stable(ctl_term), "entry lost or changed during a stall")
   `CRCI_ASSERT_NOW(a_result_from_row, clock, reset, $rose(rsp_bus.valid), $past(status.fin_pending), "result raised without a closed row")
endmodule

FILE: tb/sv/complex_row_current_injection_test.sv
`timescale 1ns / 1ps
module complex_row_current_injection_test;
   import crci_pkg::*;

   localparam int NODE_TOTAL = NODES_DEFAULT;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS = 280;
   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] Q_TWO = 32'sh0002_0000;

   typedef struct {
      logic func;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] row;
      logic signed [DATA_W-1:0] volt_re;
      logic signed [DATA_W-1:0] volt_im;
      logic signed [DATA_W-1:0] cond;
      logic signed [DATA_W-1:0] susc;
      logic last;
   } injection_item_type;

   typedef struct {
      logic [NODE_W-1:0] row;
      logic signed [DATA_W-1:0] curr_re;
      logic signed [DATA_W-1:0] curr_im;
      logic bad_index;
      logic saturated;
   } injection_result_type;

   typedef struct {
      bit is_csr;
      logic [COUNT_W-1:0] csr_value;
      injection_item_type item;
      bit typed;
      injection_result_type answer;
   } stimulus_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   crci_req_if req_if();
   crci_rsp_if rsp_if();

   complex_row_current_injection i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // Mirror of the voltage stores, the row accumulators and the column limit.
   logic signed [DATA_W-1:0] volt_e [NODE_TOTAL];
   logic signed [DATA_W-1:0] volt_f [NODE_TOTAL];
   bit loaded [NODE_TOTAL];
   longint sum_re;
   longint sum_im;
   bit row_bad;
   bit row_sat;
   logic [COUNT_W-1:0] node_limit;

   injection_result_type expected_currents[$];
   stimulus_row_type directed_rows[$];
   int failures;
   bit steady;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("Test completed with failures");
      $finish;
   end

   // Exact Q32.32 product, floored to Q16.16 by the arithmetic shift.
   function automatic longint q16_product(logic signed [DATA_W-1:0] a,
                                          logic signed [DATA_W-1:0] b);
      longint wide_a;
      longint wide_b;
      wide_a = longint'(a);
      wide_b = longint'(b);
      return (wide_a * wide_b) >>> 16;
   endfunction

   function automatic longint saturating_sum(longint acc, longint term);
      logic signed [ACC_W:0] wide;
      wide = (ACC_W+1)'(acc);
      wide = wide + (ACC_W+1)'(term);
      if (wide[ACC_W] != wide[ACC_W-1]) begin
         row_sat = 1'b1;
         return wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return wide[ACC_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] narrow_current(longint v, inout bit clamped);
      if (v > OUT_MAX) begin
         clamped = 1'b1;
         return OUT_MAX;
      end
      if (v < OUT_MIN) begin
         clamped = 1'b1;
         return OUT_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic bit accumulate_injection(injection_item_type it,
                                               output injection_result_type res);
      bit clamped;
      if (it.func == FUNC_LOAD) begin
         volt_e[it.node] = it.volt_re;
         volt_f[it.node] = it.volt_im;
         loaded[it.node] = 1'b1;
         return 1'b0;
      end
      if (it.node >= node_limit) begin
         row_bad = 1'b1;
      end else begin
         sum_re = saturating_sum(sum_re, q16_product(it.cond, volt_e[it.node])
                                 - q16_product(it.susc, volt_f[it.node]));
         sum_im = saturating_sum(sum_im, q16_product(it.cond, volt_f[it.node])
                                 + q16_product(it.susc, volt_e[it.node]));
      end
      if (!it.last) return 1'b0;
      clamped = 1'b0;
      res.row = it.row;
      res.curr_re = narrow_current(sum_re, clamped);
      res.curr_im = narrow_current(sum_im, clamped);
      res.bad_index = row_bad;
      res.saturated = row_sat | clamped;
      sum_re = 0;
      sum_im = 0;
      row_bad = 1'b0;
      row_sat = 1'b0;
      return 1'b1;
   endfunction

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] corners [6];
      corners = '{OUT_MIN, OUT_MAX, 32'sd0, -32'sd1, Q_ONE, -Q_ONE};
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         4, 5: return $urandom;
         6: return corners[$urandom_range(0, 5)];
         default: return $urandom & 32'h8000_FFFF;
      endcase
   endfunction

   function automatic void add_load(logic [NODE_W-1:0] node, logic signed [DATA_W-1:0] e,
                                    logic signed [DATA_W-1:0] f, logic last);
      stimulus_row_type r;
      r = '{default: '0};
      r.item.func = FUNC_LOAD;
      r.item.node = node;
      r.item.volt_re = e;
      r.item.volt_im = f;
      r.item.last = last;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_entry(logic [NODE_W-1:0] node, logic [NODE_W-1:0] row,
                                     logic signed [DATA_W-1:0] g,
                                     logic signed [DATA_W-1:0] b, logic last);
      stimulus_row_type r;
      r = '{default: '0};
      r.item.func = FUNC_ENTRY;
      r.item.node = node;
      r.item.row = row;
      r.item.cond = g;
      r.item.susc = b;
      r.item.last = last;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_csr(logic [COUNT_W-1:0] value);
      stimulus_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.csr_value = value;
      directed_rows.push_back(r);
   endfunction

   // Attaches a hand-computed result to the entry added just before.
   function automatic void add_answer(logic [NODE_W-1:0] row, logic signed [DATA_W-1:0] re,
                                      logic signed [DATA_W-1:0] im, logic bad, logic sat);
      stimulus_row_type r;
      r = directed_rows.pop_back();
      r.typed = 1'b1;
      r.answer.row = row;
      r.answer.curr_re = re;
      r.answer.curr_im = im;
      r.answer.bad_index = bad;
      r.answer.saturated = sat;
      directed_rows.push_back(r);
   endfunction

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endtask

   // Leaves valid high at the accepting edge so back-to-back transactions need no toggle.
   task automatic send_item(injection_item_type it);
      injection_result_type predicted;
      req_if.valid <= 1'b1;
      req_if.func <= it.func;
      req_if.node <= it.node;
      req_if.row <= it.row;
      req_if.volt_re <= it.volt_re;
      req_if.volt_im <= it.volt_im;
      req_if.cond <= it.cond;
      req_if.susc <= it.susc;
      req_if.last <= it.last;
      do @(posedge clock); while (!req_if.ready);
      if (accumulate_injection(it, predicted)) expected_currents.push_back(predicted);
   endtask

   task automatic pause_sender();
      int gap;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The limit may only change with nothing in flight, so drain the pipeline first.
   task automatic set_node_limit(logic [COUNT_W-1:0] value);
      req_if.valid <= 1'b0;
      while (expected_currents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      node_limit = value;
   endtask

   task automatic send_random_load(logic [NODE_W-1:0] node);
      injection_item_type it;
      it.func = FUNC_LOAD;
      it.node = node;
      it.row = NODE_W'($urandom);
      it.volt_re = pick_value();
      it.volt_im = pick_value();
      it.cond = $urandom;
      it.susc = $urandom;
      it.last = 1'($urandom);
      send_item(it);
      pause_sender();
   endtask

   task automatic run_random_rows(int budget);
      injection_item_type it;
      int sent;
      int len;
      logic [NODE_W-1:0] row_id;
      logic [NODE_W-1:0] col;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
         row_id = NODE_W'($urandom);
         if ($urandom_range(0, 5) == 0) steady = !steady;
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_random_load(NODE_W'($urandom));
               sent++;
            end
            if (node_limit < NODE_TOTAL && $urandom_range(0, 5) == 0)
               col = NODE_W'($urandom_range(node_limit, NODE_TOTAL - 1));
            else
               col = NODE_W'($urandom_range(0, node_limit - 1));
            // A column inside the limit is read, so its voltage must exist first.
            if (col < node_limit && !loaded[col]) begin
               send_random_load(col);
               sent++;
            end
            it.func = FUNC_ENTRY;
            it.node = col;
            it.row = row_id;
            it.volt_re = $urandom;
            it.volt_im = $urandom;
            it.cond = pick_value();
            it.susc = pick_value();
            it.last = (k == len - 1);
            send_item(it);
            pause_sender();
            sent++;
         end
      end
   endtask

   initial begin
      int stall;
      bit eager;
      stall = 0;
      eager = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) eager = !eager;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!eager) stall = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      injection_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_currents.size() == 0) begin
            $display("%0t: unexpected result for row %h", $time, rsp_if.row_out);
            failures++;
         end else begin
            want = expected_currents.pop_front();
            check_field("row_out", DATA_W'(want.row), DATA_W'(rsp_if.row_out));
            check_field("curr_re", want.curr_re, rsp_if.curr_re);
            check_field("curr_im", want.curr_im, rsp_if.curr_im);
            check_field("bad_index", DATA_W'(want.bad_index), DATA_W'(rsp_if.bad_index));
            check_field("saturated", DATA_W'(want.saturated), DATA_W'(rsp_if.saturated));
         end
      end
   end

   initial begin
      stimulus_row_type r;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.func = FUNC_LOAD;
      req_if.node = '0;
      req_if.row = '0;
      req_if.volt_re = '0;
      req_if.volt_im = '0;
      req_if.cond = '0;
      req_if.susc = '0;
      req_if.last = 1'b0;
      node_limit = NODE_COUNT_RESET;
      sum_re = 0;
      sum_im = 0;
      row_bad = 1'b0;
      row_sat = 1'b0;
      failures = 0;
      steady = 1'b0;

      add_load(8'h00, Q_ONE, Q_TWO, 1'b0);
      add_entry(8'h00, 8'h00, Q_ONE, 32'sd0, 1'b1);
      add_answer(8'h00, Q_ONE, Q_TWO, 1'b0, 1'b0);
      // A load with last set must not close a row.
      add_load(8'hFF, OUT_MIN, OUT_MIN, 1'b1);
      add_entry(8'hFF, 8'hFF, OUT_MIN, OUT_MIN, 1'b1);
      add_answer(8'hFF, 32'sd0, OUT_MAX, 1'b0, 1'b1);
      add_entry(8'hFF, 8'h5A, OUT_MAX, OUT_MAX, 1'b1);
      add_answer(8'h5A, 32'sd0, OUT_MIN, 1'b0, 1'b1);
      // The product floors, so a tiny negative term becomes -1 LSB rather than zero.
      add_load(8'h80, -32'sd1, 32'sd1, 1'b0);
      add_entry(8'h80, 8'h33, 32'sd1, 32'sd0, 1'b1);
      add_answer(8'h33, -32'sd1, 32'sd0, 1'b0, 1'b0);
      add_entry(8'h00, 8'h12, Q_TWO, Q_ONE, 1'b0);
      add_entry(8'h80, 8'h12, OUT_MAX, OUT_MIN, 1'b0);
      add_entry(8'hFF, 8'h12, Q_ONE, -Q_ONE, 1'b1);
      add_csr(9'd64);
      add_load(8'h3F, 32'sh0000_8000, 32'shFFFF_0000, 1'b0);
      add_entry(8'h80, 8'h11, Q_ONE, Q_ONE, 1'b1);
      add_answer(8'h11, 32'sd0, 32'sd0, 1'b1, 1'b0);
      add_entry(8'h40, 8'h22, Q_ONE, Q_ONE, 1'b0);
      add_entry(8'h3F, 8'h22, Q_ONE, Q_TWO, 1'b1);
      add_csr(NODE_COUNT_RESET);
      add_entry(8'hFF, 8'hEE, 32'sd0, 32'sd0, 1'b1);
      add_answer(8'hEE, 32'sd0, 32'sd0, 1'b0, 1'b0);
      // Large terms of opposite sign cancel inside the wide accumulator without a clamp.
      add_entry(8'hFF, 8'h77, OUT_MIN, OUT_MIN, 1'b0);
      add_entry(8'hFF, 8'h77, OUT_MAX, OUT_MAX, 1'b1);
      add_answer(8'h77, 32'sd0, 32'sh0001_0000, 1'b0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.is_csr) begin
            set_node_limit(r.csr_value);
         end else begin
            send_item(r.item);
            if (r.typed) expected_currents[expected_currents.size() - 1] = r.answer;
            pause_sender();
         end
      end

      set_node_limit(9'd1);
      run_random_rows(PHASE_ITEMS);
      set_node_limit(9'd255);
      run_random_rows(PHASE_ITEMS);
      set_node_limit(COUNT_W'($urandom_range(3, 254)));
      run_random_rows(PHASE_ITEMS);
      set_node_limit(9'd2);
      run_random_rows(PHASE_ITEMS);
      set_node_limit(NODE_COUNT_RESET);
      run_random_rows(PHASE_ITEMS);
      req_if.valid <= 1'b0;

      while (expected_currents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/crci_pkg.sv
hdl/crci_req_if.sv
hdl/crci_rsp_if.sv
hdl/crci_store.sv
hdl/crci_mult.sv
hdl/crci_accum.sv
hdl/complex_row_current_injection.sv
tb/sv/complex_row_current_injection_test.sv
